@@ rtl/fet_pkg.sv @@
// Shared constants, register indexes and sequencer states of the escape-time evaluator.
`default_nettype none

package fet_pkg;

  // Pixel index width and fixed-point fraction width of all coordinates.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;

  // Field widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 16;
  localparam int GREY_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_RE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_IM = 3'd6;

  // Reset values of the configuration registers.
  localparam logic signed [COORD_W-1:0] ORIGIN_RST = COORD_W'(-(64'sd2 <<< FRAC_BITS));
  localparam logic [STEP_W-1:0] PIXEL_STEP_RST = STEP_W'(64'd1 << (FRAC_BITS - 10));
  localparam logic [ITER_W-1:0] MAX_ITER_RST   = ITER_W'(255);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_RE,
    ST_PT_IM,
    ST_PT_DONE,
    ST_SQ_RR,
    ST_SQ_II,
    ST_SQ_RI,
    ST_UPD,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ rtl/fet_ifs.sv @@
// Handshake interfaces for the pixel, result and configuration channels.
`default_nettype none

interface fet_pix_if;
  import fet_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

interface fet_res_if;
  import fet_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [GREY_W-1:0]     grey_level;
  logic [COORD_BITS-1:0] column_out;
  logic [COORD_BITS-1:0] row_out;
  modport source (output valid, grey_level, column_out, row_out, input ready);
  modport sink (input valid, grey_level, column_out, row_out, output ready);
endinterface

interface fet_cfg_if;
  import fet_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/fractal_escape_time.sv @@
// Escape-time fractal pixel evaluator (Mandelbrot or Julia) with one shared multiplier.
//
// Usage:
//   cfg_i  : register writes (index, data); always ready. Write only while no pixel
//            is in flight and no result is waiting.
//   pix_i  : one transaction names one pixel by column and row. Ready only while
//            the sequencer is idle; one pixel is evaluated at a time.
//   res_o  : one transaction per pixel with the grey level and the echoed indices.
// Timing: a pixel forms its point and picks start values (PT_RE, PT_IM, PT_DONE),
//   then each iteration forms three products through the one 33x33 multiplier
//   (SQ_RR, SQ_II, SQ_RI) plus an update step (UPD), and the done state hands the
//   result over; an escaping point also forms the three products of its failing test.
//   The next pixel is taken in the cycle after the result enters the output register.
// Stall: the result waits in the output register while res_o.ready is low; a new
//   pixel is still accepted, and its own result waits in the done state until the
//   output register frees up.
// Reset: asynchronous, active low; restores all configuration registers to their
//   defaults (Mandelbrot, origin -2-2i, step 2^-10, limit 255) and empties the output.
`default_nettype none

module fractal_escape_time (
  input  wire        clk_i,
  input  wire        rst_ni,
  fet_cfg_if.sink    cfg_i,
  fet_pix_if.sink    pix_i,
  fet_res_if.source  res_o
);
  import fet_pkg::*;

  localparam int MUL_W     = 33;
  localparam int WIDE_W    = 64;
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam int ESC_SH_C  = (ESC_SHIFT < WIDE_W) ? ESC_SHIFT : WIDE_W - 1;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -64'sd2147483648;

  // Clamp a wide signed value to the signed 32-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic                      julia_q;
  logic signed [COORD_W-1:0] origin_re_q;
  logic signed [COORD_W-1:0] origin_im_q;
  logic [STEP_W-1:0]         pixel_step_q;
  logic [ITER_W-1:0]         max_iter_q;
  logic signed [COORD_W-1:0] c_fix_re_q;
  logic signed [COORD_W-1:0] c_fix_im_q;

  // Sequencer and datapath.
  state_e                    state_q, state_d;
  logic [COORD_BITS-1:0]     col_q, row_q;
  logic [ITER_W-1:0]         step_q;
  logic [ITER_W:0]           step_inc;
  logic signed [COORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [WIDE_W-1:0]  prod_q, rr_q, diff_q;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [WIDE_W-1:0]  pt_origin, pt_sum;
  logic signed [COORD_W-1:0] pt_val;
  logic [WIDE_W-1:0]         mag;
  logic                      escaped;
  logic                      pix_acc;
  logic                      res_load;

  // Output register.
  logic                      res_valid_q;
  logic [GREY_W-1:0]         grey_q;
  logic [COORD_BITS-1:0]     col_out_q, row_out_q;

  // Configuration writes; the port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_q      <= 1'b0;
      origin_re_q  <= ORIGIN_RST;
      origin_im_q  <= ORIGIN_RST;
      pixel_step_q <= PIXEL_STEP_RST;
      max_iter_q   <= MAX_ITER_RST;
      c_fix_re_q   <= '0;
      c_fix_im_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_JULIA_MODE: julia_q      <= cfg_i.data[0];
        CFG_ORIGIN_RE:  origin_re_q  <= cfg_i.data;
        CFG_ORIGIN_IM:  origin_im_q  <= cfg_i.data;
        CFG_PIXEL_STEP: pixel_step_q <= cfg_i.data[STEP_W-1:0];
        CFG_MAX_ITER:   max_iter_q   <= cfg_i.data[ITER_W-1:0];
        CFG_JULIA_C_RE: c_fix_re_q   <= cfg_i.data;
        CFG_JULIA_C_IM: c_fix_im_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The shared multiplier; its product is always registered in prod_q.
  assign mul_p = mul_a * mul_b;

  // Point coordinate from the previous product, clamped.
  assign pt_origin = (state_q == ST_PT_IM) ? WIDE_W'(origin_re_q) : WIDE_W'(origin_im_q);
  assign pt_sum    = pt_origin + prod_q;
  assign pt_val    = sat32(pt_sum);

  // Escape test: |z|^2 from rr_q and the square of the imaginary part in prod_q.
  assign mag      = WIDE_W'($unsigned(rr_q)) + WIDE_W'($unsigned(prod_q));
  assign escaped  = (ESC_SHIFT < WIDE_W) && ((mag >> ESC_SH_C) != '0);
  assign step_inc = {1'b0, step_q} + 17'd1;
  assign pix_acc  = pix_i.valid && pix_i.ready;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, multiplier operands and handshake outputs.
  always_comb begin
    state_d     = state_q;
    pix_i.ready = (state_q == ST_IDLE);
    res_load    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      ST_IDLE: begin
        if (pix_i.valid) state_d = ST_PT_RE;
      end
      ST_PT_RE: begin
        mul_a   = MUL_W'(col_q);
        mul_b   = MUL_W'(pixel_step_q);
        state_d = ST_PT_IM;
      end
      ST_PT_IM: begin
        mul_a   = MUL_W'(row_q);
        mul_b   = MUL_W'(pixel_step_q);
        state_d = ST_PT_DONE;
      end
      ST_PT_DONE: begin
        state_d = (max_iter_q == '0) ? ST_DONE : ST_SQ_RR;
      end
      ST_SQ_RR: begin
        mul_a   = MUL_W'(zr_q);
        mul_b   = MUL_W'(zr_q);
        state_d = ST_SQ_II;
      end
      ST_SQ_II: begin
        mul_a   = MUL_W'(zi_q);
        mul_b   = MUL_W'(zi_q);
        state_d = ST_SQ_RI;
      end
      ST_SQ_RI: begin
        mul_a   = MUL_W'(zr_q);
        mul_b   = MUL_W'(zi_q);
        state_d = escaped ? ST_DONE : ST_UPD;
      end
      ST_UPD: begin
        state_d = (step_inc < {1'b0, max_iter_q}) ? ST_SQ_RR : ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Iteration count, which alone among the datapath registers needs a known start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (pix_acc) begin
      step_q <= '0;
    end else if (state_q == ST_UPD) begin
      step_q <= step_inc[ITER_W-1:0];
    end
  end

  // Datapath registers: pixel indices, products and the complex values.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[WIDE_W-1:0];
    if (pix_acc) begin
      col_q <= pix_i.column;
      row_q <= pix_i.row;
    end
    case (state_q)
      ST_PT_IM: begin
        if (julia_q) begin
          zr_q <= pt_val;
          cr_q <= c_fix_re_q;
        end else begin
          zr_q <= '0;
          cr_q <= pt_val;
        end
      end
      ST_PT_DONE: begin
        if (julia_q) begin
          zi_q <= pt_val;
          ci_q <= c_fix_im_q;
        end else begin
          zi_q <= '0;
          ci_q <= pt_val;
        end
      end
      ST_SQ_II: rr_q <= prod_q;
      ST_SQ_RI: diff_q <= rr_q - prod_q;
      ST_UPD: begin
        zr_q <= sat32((diff_q >>> FRAC_BITS) + WIDE_W'(cr_q));
        zi_q <= sat32((prod_q >>> (FRAC_BITS - 1)) + WIDE_W'(ci_q));
      end
      default: ;
    endcase
  end

  // Output register: filled from the done state, emptied by the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      grey_q    <= step_q[GREY_W-1:0];
      col_out_q <= col_q;
      row_out_q <= row_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.grey_level = grey_q;
  assign res_o.column_out = col_out_q;
  assign res_o.row_out    = row_out_q;

`ifndef SYNTHESIS
  // A freshly accepted pixel cannot produce a result in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> !res_load)
    else $error("result loaded right after a pixel was accepted");

  // z holds while its square products are being formed.
  a_z_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_II) |=> (zr_q == $past(zr_q) && zi_q == $past(zi_q)))
    else $error("z changed between its products");

  // The iteration count only clears or advances by one.
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != $past(step_q)) |-> (step_q == $past(step_q) + 16'd1 || step_q == '0))
    else $error("iteration count jumped");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench of the escape-time fractal pixel evaluator.
module tb_top;
  import fet_pkg::*;

  // Register index that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int PLAN_LEN     = 47;
  localparam longint unsigned ESCAPE_BOUND = 64'd1 << (2 * FRAC_BITS + 2);

  typedef enum logic [1:0] {PLAN_WRITE, PLAN_PIXEL, PLAN_PIXEL_KNOWN} plan_kind_e;

  typedef struct packed {
    plan_kind_e            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] lin;
    logic [GREY_W-1:0]     grey;
  } plan_row_t;

  typedef struct {
    logic [GREY_W-1:0]     grey;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  fet_cfg_if cfg_if ();
  fet_pix_if pix_if ();
  fet_res_if res_if ();

  fractal_escape_time u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  // Shadow copy of the configuration registers.
  logic                     julia_q;
  logic signed [COORD_W-1:0] origin_re_q;
  logic signed [COORD_W-1:0] origin_im_q;
  logic [STEP_W-1:0]        step_q;
  logic [ITER_W-1:0]        max_iter_q;
  logic signed [COORD_W-1:0] jc_re_q;
  logic signed [COORD_W-1:0] jc_im_q;

  pixel_result_t expected_pixels[$];
  plan_row_t     plan [PLAN_LEN];

  bit src_idle_en;
  bit sink_idle_en;
  int sink_gap;
  int mismatches;
  int checked;
  int julia_px;
  int mandel_px;
  int settings;
  int cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Number of z -> z*z + c steps taken before escape or the limit, modulo 256.
  function automatic logic [GREY_W-1:0] escape_steps(input logic [COORD_BITS-1:0] col,
                                                     input logic [COORD_BITS-1:0] lin);
    longint          pt_re, pt_im, zr, zi, cr, ci, rr, ii, ri;
    longint unsigned mag;
    int unsigned     n;
    bit              escaped;
    pt_re = clamp32(longint'(origin_re_q) + longint'(col) * longint'(step_q));
    pt_im = clamp32(longint'(origin_im_q) + longint'(lin) * longint'(step_q));
    if (julia_q) begin
      zr = pt_re;
      zi = pt_im;
      cr = longint'(jc_re_q);
      ci = longint'(jc_im_q);
    end else begin
      zr = 0;
      zi = 0;
      cr = pt_re;
      ci = pt_im;
    end
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < max_iter_q) begin
      rr = zr * zr;
      ii = zi * zi;
      mag = $unsigned(rr) + $unsigned(ii);
      if (mag >= ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        ri = zr * zi;
        // Arithmetic shifts round toward minus infinity, as the datapath does.
        zr = clamp32(((rr - ii) >>> FRAC_BITS) + cr);
        zi = clamp32((ri >>> (FRAC_BITS - 1)) + ci);
        n++;
      end
    end
    return n[GREY_W-1:0];
  endfunction

  // Drive one pixel transaction and record what it should produce.
  task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] lin,
                            input bit known, input logic [GREY_W-1:0] known_grey);
    pixel_result_t want;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pix_if.valid  <= 1'b1;
    pix_if.column <= col;
    pix_if.row    <= lin;
    do @(posedge clk); while (pix_if.ready !== 1'b1);
    want.grey   = known ? known_grey : escape_steps(col, lin);
    want.column = col;
    want.row    = lin;
    expected_pixels.push_back(want);
    if (julia_q) julia_px++;
    else mandel_px++;
  endtask

  // Stop sending and wait until every pending pixel has come back.
  task automatic drain();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write transaction; the shadow copy follows the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_JULIA_MODE: julia_q     = value[0];
      CFG_ORIGIN_RE:  origin_re_q = value;
      CFG_ORIGIN_IM:  origin_im_q = value;
      CFG_PIXEL_STEP: step_q      = value[STEP_W-1:0];
      CFG_MAX_ITER:   max_iter_q  = value[ITER_W-1:0];
      CFG_JULIA_C_RE: jc_re_q     = value;
      CFG_JULIA_C_IM: jc_im_q     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result receiver: ready drops in short random bursts.
  always @(negedge clk) begin
    if (sink_gap == 0 && sink_idle_en && $urandom_range(0, 4) == 0)
      sink_gap = $urandom_range(1, 3);
    if (sink_gap > 0) begin
      res_if.ready <= 1'b0;
      sink_gap--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result grey=%0d col=%0d row=%0d",
                   res_if.grey_level, res_if.column_out, res_if.row_out);
      end else begin
        want = expected_pixels.pop_front();
        checked++;
        if (res_if.grey_level !== want.grey || res_if.column_out !== want.column ||
            res_if.row_out !== want.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: pixel (%0d,%0d) expected grey=%0d col=%0d row=%0d, got %0d %0d %0d",
                     want.column, want.row, want.grey, want.column, want.row,
                     res_if.grey_level, res_if.column_out, res_if.row_out);
        end
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
             expected_pixels.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Reset, directed table, then random register settings with pixel batches.
  initial begin
    int unsigned flavor;
    int unsigned batch;
    int unsigned sent;
    int unsigned pick;
    logic [31:0] o_re, o_im, c_re, c_im, stp, junk;
    logic [ITER_W-1:0] iters;
    logic [COORD_BITS-1:0] col, lin;
    bit jmode;

    plan = '{
      // Reset defaults: Mandelbrot over -2..2 in both axes, limit 255.
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    8'd1},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd4095, 12'd4095, 8'd1},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd255},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd1024, 12'd2048, 8'd255},
      '{PLAN_PIXEL,       '0, '0, 12'd1536, 12'd2560, 8'd0},
      '{PLAN_PIXEL,       '0, '0, 12'd4095, 12'd0,    8'd0},
      '{PLAN_PIXEL,       '0, '0, 12'd0,    12'd4095, 8'd0},
      '{PLAN_PIXEL,       '0, '0, 12'd2400, 12'd2800, 8'd0},
      // Zero limit, a limit past 256, and the largest limit.
      '{PLAN_WRITE, CFG_MAX_ITER, 32'h0000_0000, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd0},
      '{PLAN_WRITE, CFG_MAX_ITER, 32'd300, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd44},
      '{PLAN_WRITE, CFG_MAX_ITER, 32'hFFFF_FFFF, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    8'd1},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd255},
      '{PLAN_WRITE, CFG_MAX_ITER, 32'h5A5A_00FF, '0, '0, '0},
      // Point coordinates saturate high, then sit at the most negative value.
      '{PLAN_WRITE, CFG_ORIGIN_RE,  32'h7FFF_FFFF, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_IM,  32'h7FFF_FFFF, '0, '0, '0},
      '{PLAN_WRITE, CFG_PIXEL_STEP, 32'hFFFF_FFFF, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd4095, 12'd4095, 8'd1},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    8'd1},
      '{PLAN_WRITE, CFG_ORIGIN_RE,  32'h8000_0000, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_IM,  32'h8000_0000, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    8'd1},
      '{PLAN_PIXEL,       '0, '0, 12'd4095, 12'd1,    8'd0},
      // A zero step puts every pixel on the origin.
      '{PLAN_WRITE, CFG_PIXEL_STEP, 32'h0000_0000, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_RE,  32'h0000_0000, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_IM,  32'h0000_0000, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd4095, 12'd4095, 8'd255},
      // A write to an unknown index must leave every register alone.
      '{PLAN_WRITE, CFG_UNUSED,     32'hFFFF_FFFF, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_RE,  32'hE000_0000, '0, '0, '0},
      '{PLAN_WRITE, CFG_ORIGIN_IM,  32'hE000_0000, '0, '0, '0},
      '{PLAN_WRITE, CFG_PIXEL_STEP, 32'h0004_0000, '0, '0, '0},
      // Julia mode, first with c at zero, then a classic c, then saturating c.
      '{PLAN_WRITE, CFG_JULIA_MODE, 32'h0000_0001, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd0,    12'd0,    8'd0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd255},
      '{PLAN_WRITE, CFG_JULIA_C_RE, 32'hF333_3333, '0, '0, '0},
      '{PLAN_WRITE, CFG_JULIA_C_IM, 32'h0280_0000, '0, '0, '0},
      '{PLAN_PIXEL,       '0, '0, 12'd1500, 12'd2100, 8'd0},
      '{PLAN_PIXEL,       '0, '0, 12'd2600, 12'd1900, 8'd0},
      '{PLAN_PIXEL,       '0, '0, 12'd3000, 12'd2048, 8'd0},
      '{PLAN_WRITE, CFG_JULIA_C_RE, 32'h7FFF_FFFF, '0, '0, '0},
      '{PLAN_WRITE, CFG_JULIA_C_IM, 32'h8000_0000, '0, '0, '0},
      '{PLAN_PIXEL_KNOWN, '0, '0, 12'd2048, 12'd2048, 8'd1},
      '{PLAN_PIXEL,       '0, '0, 12'd2600, 12'd2100, 8'd0},
      // Back to Mandelbrot; only bit zero of the mode write counts.
      '{PLAN_WRITE, CFG_JULIA_MODE, 32'hFFFF_FFFE, '0, '0, '0},
      '{PLAN_PIXEL,       '0, '0, 12'd2048, 12'd2048, 8'd0}
    };

    // All inputs known from time zero; reset held low, then released at a falling clock edge.
    rst_n         = 1'b0;
    pix_if.valid  = 1'b0;
    pix_if.column = '0;
    pix_if.row    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    sink_gap      = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    julia_q       = 1'b0;
    origin_re_q   = ORIGIN_RST;
    origin_im_q   = ORIGIN_RST;
    step_q        = PIXEL_STEP_RST;
    max_iter_q    = MAX_ITER_RST;
    jc_re_q       = '0;
    jc_im_q       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_WRITE) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        settings++;
      end else begin
        send_pixel(plan[i].col, plan[i].lin, plan[i].kind == PLAN_PIXEL_KNOWN, plan[i].grey);
      end
    end

    // Random part: each phase programs a new view and sends a batch of pixels.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      flavor = $urandom_range(0, 9);
      c_re = $urandom;
      c_im = $urandom;
      stp  = $urandom;
      if (flavor <= 4) begin
        // Mandelbrot view around the main cardioid.
        jmode = 1'b0;
        o_re = $urandom_range(0, 32'h2000_0000) - 32'h2800_0000;
        o_im = $urandom_range(0, 32'h1000_0000) - 32'h2000_0000;
        stp[30:0] = STEP_W'($urandom_range(32'h1_0000, 32'h8_0000));
      end else if (flavor <= 7) begin
        // Julia view with c inside the unit square.
        jmode = 1'b1;
        o_re = $urandom_range(0, 32'h1000_0000) - 32'h2000_0000;
        o_im = $urandom_range(0, 32'h1000_0000) - 32'h2000_0000;
        stp[30:0] = STEP_W'($urandom_range(32'h1_0000, 32'h4_0000));
        c_re = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        c_im = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      end else begin
        // Anything goes, saturation included.
        jmode = 1'($urandom_range(0, 1));
        o_re = $urandom;
        o_im = $urandom;
      end

      // Mostly short limits keep the run short; a few phases use long ones.
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        iters = '0;
        batch = $urandom_range(10, 30);
      end else if (pick <= 13) begin
        iters = ITER_W'($urandom_range(1, 32));
        batch = $urandom_range(20, 60);
      end else if (pick <= 17) begin
        iters = ITER_W'($urandom_range(33, 120));
        batch = $urandom_range(15, 40);
      end else if (pick == 18) begin
        iters = 16'd255;
        batch = 10;
      end else begin
        iters = ITER_W'($urandom_range(256, 300));
        batch = 6;
      end

      junk = $urandom;
      write_reg(CFG_JULIA_MODE, {junk[31:1], jmode});
      write_reg(CFG_ORIGIN_RE, o_re);
      write_reg(CFG_ORIGIN_IM, o_im);
      write_reg(CFG_PIXEL_STEP, stp);
      junk = $urandom;
      write_reg(CFG_MAX_ITER, {junk[31:16], iters});
      write_reg(CFG_JULIA_C_RE, c_re);
      write_reg(CFG_JULIA_C_IM, c_im);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
      settings++;

      // Idling on some phases only, and none in the closing stretch.
      if (sent >= RANDOM_ITEMS - RANDOM_ITEMS / 8) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en  = $urandom_range(0, 3) != 0;
        sink_idle_en = $urandom_range(0, 3) != 0;
      end

      repeat (batch) begin
        if (sent < RANDOM_ITEMS) begin
          col = COORD_BITS'($urandom_range(0, 4095));
          lin = COORD_BITS'($urandom_range(0, 4095));
          if ($urandom_range(0, 15) == 0) col = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          if ($urandom_range(0, 15) == 0) lin = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          send_pixel(col, lin, 1'b0, '0);
          sent++;
        end
      end
    end

    // Let everything come back, then a short quiet period.
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d pixels (%0d Mandelbrot, %0d Julia) across %0d register settings.",
             mandel_px + julia_px, mandel_px, julia_px, settings);
    $display("Results checked: %0d, mismatching or unexpected: %0d.", checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
